### hw/rtl/bbf_pkg.sv
// shared types, codes and sizes for the bounded byte fifo
`timescale 1ns / 1ps
`default_nettype none

package bbf_pkg;

    // buffer geometry (power-of-two depth, pointers wrap by truncation)
    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 13;
    localparam int TOT_W  = 48;
    localparam int BYTE_W = 8;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 152;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 13'd4096;

    // operation codes
    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_READ  = 3'd1,
        MODE_PEEK  = 3'd2,
        MODE_POP   = 3'd3,
        MODE_END   = 3'd4
    } mode_t;

    // memory port request from the core
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // status of one finished request, byte itself comes from the memory
    typedef struct packed {
        logic             byte_valid;
        logic [CNT_W-1:0] moved;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] room_left;
        logic [TOT_W-1:0] total_written;
        logic [TOT_W-1:0] total_read;
        logic             writer_done;
        logic             end_of_stream;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/bbf_ram.sv
// simple dual-port byte memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bbf_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 12
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bbf_core.sv
// request decode, pointer and counter state, result stage register
`timescale 1ns / 1ps
`default_nettype none

module bbf_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [2:0]              mode,
    input  wire logic [7:0]              write_byte,
    input  wire logic [12:0]             amount,
    input  wire logic [12:0]             capacity,
    input  wire logic                    res_take,
    output logic                         res_valid,
    output bbf_pkg::result_t             res,
    output bbf_pkg::ram_req_t            ram_req
);

    import bbf_pkg::*;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic [TOT_W-1:0]  wtot_reg, wtot_next;
    logic [TOT_W-1:0]  rtot_reg, rtot_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  room_now;
    logic [CNT_W-1:0]  pop_n;
    logic              peek_hit;
    logic              byte_valid;
    logic [CNT_W-1:0]  moved;

    // capacity limited to the physical depth, room before this request
    always_comb
    begin
        eff_cap  = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
        room_now = (eff_cap > count_reg) ? eff_cap - count_reg : '0;
        pop_n    = (amount < count_reg) ? amount : count_reg;
        peek_hit = amount < count_reg;
    end

    // operation decode and next state
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        wtot_next       = wtot_reg;
        rtot_next       = rtot_reg;
        byte_valid      = 1'b0;
        moved           = '0;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = front_reg + count_reg[ADDR_W-1:0];
        ram_req.wr_data = write_byte;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = front_reg;
        case (mode)
            MODE_WRITE:
            begin
                if (room_now != '0)
                begin
                    ram_req.wr_en = accept;
                    count_next    = count_reg + CNT_W'(1);
                    wtot_next     = wtot_reg + TOT_W'(1);
                    moved         = CNT_W'(1);
                end
            end
            MODE_READ:
            begin
                if (count_reg != '0)
                begin
                    ram_req.rd_en = accept;
                    byte_valid    = 1'b1;
                    moved         = CNT_W'(1);
                    front_next    = front_reg + ADDR_W'(1);
                    count_next    = count_reg - CNT_W'(1);
                    rtot_next     = rtot_reg + TOT_W'(1);
                end
            end
            MODE_PEEK:
            begin
                ram_req.rd_addr = front_reg + amount[ADDR_W-1:0];
                if (peek_hit)
                begin
                    ram_req.rd_en = accept;
                    byte_valid    = 1'b1;
                end
            end
            MODE_POP:
            begin
                moved      = pop_n;
                front_next = front_reg + pop_n[ADDR_W-1:0];
                count_next = count_reg - pop_n;
                rtot_next  = rtot_reg + TOT_W'(pop_n);
            end
            MODE_END:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                moved = '0;
            end
        endcase
    end

    // status after this request
    always_comb
    begin
        res_next.byte_valid    = byte_valid;
        res_next.moved         = moved;
        res_next.fill_level    = count_next;
        res_next.room_left     = (eff_cap > count_next) ? eff_cap - count_next : '0;
        res_next.total_written = wtot_next;
        res_next.total_read    = rtot_next;
        res_next.writer_done   = done_next;
        res_next.end_of_stream = done_next && (count_next == '0);
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            wtot_reg      <= '0;
            rtot_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
                done_reg  <= done_next;
                wtot_reg  <= wtot_next;
                rtot_reg  <= rtot_next;
            end
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### hw/rtl/bbf_out.sv
// output register: joins status and memory byte, decouples the master side
`timescale 1ns / 1ps
`default_nettype none

module bbf_out (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             res_valid,
    input  wire bbf_pkg::result_t                 res,
    input  wire logic [7:0]                       rd_data,
    output logic                                  res_take,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bbf_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tlast
);

    import bbf_pkg::*;

    logic                  valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic                  last_reg;
    logic [BYTE_W-1:0]     out_byte;

    // byte reads zero when nothing was delivered
    always_comb
    begin
        out_byte  = res.byte_valid ? rd_data : '0;
        data_next = {7'd0, res.writer_done, res.total_read, res.total_written,
                     res.room_left, res.fill_level, res.moved, res.byte_valid, out_byte};
        res_take  = res_valid && (!valid_reg || m_tready);
        if (res_take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            data_reg <= data_next;
            last_reg <= res.end_of_stream;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### hw/rtl/bounded_byte_fifo.sv
// top level of the bounded byte fifo
`timescale 1ns / 1ps
`default_nettype none

// Byte FIFO of 4096 entries with a programmable capacity limit. Every request
// (write, read, peek, pop, end of input) yields one status result. One request
// is taken every clock cycle while the master side keeps up. The edge that
// takes a request updates the pointers, registers the status in the result
// stage and does the registered memory read; the output register loads the
// status and the byte once it is empty or m_tready is high, and raises
// m_tvalid. With the master side stalled, two results are held and s_tready
// drops until one is taken. The byte memory needs no initialisation, so the
// block is ready straight after reset. The capacity register is to be written
// by the user only while the block is idle; the block does not enforce this.

module bounded_byte_fifo (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // mode[2:0], write_byte[10:3], amount[23:11]
    input  wire logic [bbf_pkg::IN_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0], byte_valid[8], moved[21:9], fill_level[34:22],
    // room_left[47:35], total_written[95:48], total_read[143:96],
    // writer_done[144], zero[151:145]
    output logic [bbf_pkg::OUT_DATA_W-1:0]        m_tdata,
    // end_of_stream
    output logic                                  m_tlast,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bbf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [bbf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bbf_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    import bbf_pkg::*;

    logic [CNT_W-1:0] capacity_reg, capacity_next;
    logic             cfg_wr;
    logic             accept;
    logic             res_valid;
    logic             res_take;
    result_t          res;
    ram_req_t         ram_req;
    logic [BYTE_W-1:0] rd_data;

    // configuration register
    always_comb
    begin
        cfg_wr        = psel && penable && pwrite && pready;
        capacity_next = capacity_reg;
        if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY))
        begin
            capacity_next = pwdata[CNT_W-1:0];
        end
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY)
        begin
            prdata = CFG_DATA_W'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign pready = 1'b1;

    // request handshake
    assign s_tready = !res_valid || res_take;
    assign accept   = s_tvalid && s_tready;

    bbf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (s_tdata[2:0]),
        .write_byte (s_tdata[10:3]),
        .amount     (s_tdata[23:11]),
        .capacity   (capacity_reg),
        .res_take   (res_take),
        .res_valid  (res_valid),
        .res        (res),
        .ram_req    (ram_req)
    );

    bbf_ram #(
        .DATA_W (BYTE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.wr_en),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.wr_data),
        .re    (ram_req.rd_en),
        .raddr (ram_req.rd_addr),
        .rdata (rd_data)
    );

    bbf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .rd_data   (rd_data),
        .res_take  (res_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/bbf_checker.sv
// port-level checks for the bounded byte fifo, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bbf_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bbf_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire logic                             m_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // fill level never exceeds the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34:22] <= 13'd4096)
        else $error("fill level beyond depth");

    // end of stream only with input ended and an empty buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[144] && (m_tdata[34:22] == 13'd0))
        else $error("end of stream without ended, empty buffer");

    // no byte delivered reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("byte not zero without valid");

endmodule

bind bounded_byte_fifo bbf_checker u_bbf_checker (.*);

`default_nettype wire

### sim/tb_bounded_byte_fifo.sv
// self-checking testbench for the bounded byte fifo: mirrored buffer, stream and register traffic
`timescale 1ns / 1ps
module tb_bounded_byte_fifo;
    import bbf_pkg::*;

    localparam int AMOUNT_MAX    = (1 << CNT_W) - 1;
    localparam int BYTE_MAX      = (1 << BYTE_W) - 1;
    localparam int MODE_CODE_MAX = (1 << 3) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int SMALL_CAP     = 64;

    // one status result as the block reports it
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [CNT_W-1:0]  moved;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  room_left;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              writer_done;
        logic              end_of_stream;
    } fifo_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // mode[2:0], write_byte[10:3], amount[23:11]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_byte[7:0], byte_valid[8], moved[21:9], fill_level[34:22],
    // room_left[47:35], total_written[95:48], total_read[143:96],
    // writer_done[144], zero[151:145]
    logic [OUT_DATA_W-1:0] m_tdata;
    // end_of_stream
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // mirrored buffer state
    logic [BYTE_W-1:0]     mirror_bytes [DEPTH];
    logic [ADDR_W-1:0]     mirror_front = '0;
    logic [CNT_W-1:0]      mirror_count = '0;
    logic                  mirror_done = 1'b0;
    logic [TOT_W-1:0]      mirror_wr_total = '0;
    logic [TOT_W-1:0]      mirror_rd_total = '0;
    logic [CNT_W-1:0]      mirror_capacity = CAPACITY_RESET;

    fifo_status_t          due_status [$];
    int                    error_count = 0;
    int                    tx_idle_pct = 0;
    int                    rx_stall_pct = 0;

    bounded_byte_fifo uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // room under the capacity limit, never more than the store depth
    function automatic logic [CNT_W-1:0] mirror_room();
        logic [CNT_W-1:0] cap;
        cap = (mirror_capacity > DEPTH) ? CNT_W'(DEPTH) : mirror_capacity;
        return (cap > mirror_count) ? cap - mirror_count : '0;
    endfunction

    // apply one request to the mirror and return the status it yields
    function automatic fifo_status_t apply_request(input logic [2:0] mode,
                                                   input logic [BYTE_W-1:0] wbyte,
                                                   input logic [CNT_W-1:0] amount);
        fifo_status_t     st;
        logic [ADDR_W-1:0] slot_idx;
        logic [CNT_W-1:0]  take;
        st = '0;
        case (mode)
            MODE_WRITE:
            begin
                if (mirror_room() != 0)
                begin
                    slot_idx = mirror_front + mirror_count[ADDR_W-1:0];
                    mirror_bytes[slot_idx] = wbyte;
                    mirror_count = mirror_count + 1'b1;
                    mirror_wr_total = mirror_wr_total + 1'b1;
                    st.moved = CNT_W'(1);
                end
            end
            MODE_READ:
            begin
                if (mirror_count != 0)
                begin
                    st.out_byte = mirror_bytes[mirror_front];
                    st.byte_valid = 1'b1;
                    st.moved = CNT_W'(1);
                    mirror_front = mirror_front + 1'b1;
                    mirror_count = mirror_count - 1'b1;
                    mirror_rd_total = mirror_rd_total + 1'b1;
                end
            end
            MODE_PEEK:
            begin
                if (amount < mirror_count)
                begin
                    slot_idx = mirror_front + amount[ADDR_W-1:0];
                    st.out_byte = mirror_bytes[slot_idx];
                    st.byte_valid = 1'b1;
                end
            end
            MODE_POP:
            begin
                take = (amount < mirror_count) ? amount : mirror_count;
                mirror_front = mirror_front + take[ADDR_W-1:0];
                mirror_count = mirror_count - take;
                mirror_rd_total = mirror_rd_total + TOT_W'(take);
                st.moved = take;
            end
            MODE_END:
            begin
                mirror_done = 1'b1;
            end
            default:
            begin
            end
        endcase
        st.fill_level = mirror_count;
        st.room_left = mirror_room();
        st.total_written = mirror_wr_total;
        st.total_read = mirror_rd_total;
        st.writer_done = mirror_done;
        st.end_of_stream = mirror_done && (mirror_count == 0);
        return st;
    endfunction

    task automatic check_field(input string field, input logic [TOT_W-1:0] want,
                               input logic [TOT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic compare_status(input fifo_status_t want, input fifo_status_t got);
        check_field("out_byte", TOT_W'(want.out_byte), TOT_W'(got.out_byte));
        check_field("byte_valid", TOT_W'(want.byte_valid), TOT_W'(got.byte_valid));
        check_field("moved", TOT_W'(want.moved), TOT_W'(got.moved));
        check_field("fill_level", TOT_W'(want.fill_level), TOT_W'(got.fill_level));
        check_field("room_left", TOT_W'(want.room_left), TOT_W'(got.room_left));
        check_field("total_written", want.total_written, got.total_written);
        check_field("total_read", want.total_read, got.total_read);
        check_field("writer_done", TOT_W'(want.writer_done), TOT_W'(got.writer_done));
        check_field("end_of_stream", TOT_W'(want.end_of_stream),
                    TOT_W'(got.end_of_stream));
    endtask

    // result side: random stalls and a check of every accepted result
    always @(posedge clk)
    begin : result_check
        fifo_status_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.out_byte      = m_tdata[7:0];
            seen.byte_valid    = m_tdata[8];
            seen.moved         = m_tdata[21:9];
            seen.fill_level    = m_tdata[34:22];
            seen.room_left     = m_tdata[47:35];
            seen.total_written = m_tdata[95:48];
            seen.total_read    = m_tdata[143:96];
            seen.writer_done   = m_tdata[144];
            seen.end_of_stream = m_tlast;
            if (due_status.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, seen);
                error_count++;
            end
            else
            begin
                compare_status(due_status[0], seen);
                due_status.delete(0);
            end
        end
        m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // send one request and record the status it should produce
    task automatic issue_request(input logic [2:0] mode, input logic [BYTE_W-1:0] wbyte,
                                 input logic [CNT_W-1:0] amount);
        fifo_status_t want;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {amount, wbyte, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = apply_request(mode, wbyte, amount);
        due_status.insert(due_status.size(), want);
    endtask

    // stop sending and wait until every result is back and the pipeline is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the capacity register while idle, then read it back
    task automatic program_capacity(input logic [CFG_DATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_CAPACITY) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror_capacity = value[CNT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("capacity readback", TOT_W'(mirror_capacity),
                    TOT_W'(prdata[CNT_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // offsets and counts: mostly near the fill level, sometimes anywhere
    function automatic logic [CNT_W-1:0] pick_amount();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return CNT_W'($urandom_range(int'(mirror_count) + 1, 0));
        if (roll < 75)
            return mirror_count;
        return CNT_W'($urandom_range(AMOUNT_MAX, 0));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        return BYTE_W'($urandom_range(BYTE_MAX, 0));
    endfunction

    // bursts of writes and reads mixed with single peeks, pops, unused codes, writes and, if allowed, ends
    task automatic run_random_mix(input int request_total, input bit allow_end);
        int sent;
        int burst;
        int roll;
        sent = 0;
        while (sent < request_total)
        begin
            roll = $urandom_range(99);
            burst = $urandom_range(12, 1);
            if (roll < 30)
            begin
                repeat (burst) issue_request(MODE_WRITE, pick_byte(), pick_amount());
                sent += burst;
            end
            else if (roll < 50)
            begin
                repeat (burst) issue_request(MODE_READ, pick_byte(), pick_amount());
                sent += burst;
            end
            else
            begin
                if (roll < 64)
                    issue_request(MODE_PEEK, pick_byte(), pick_amount());
                else if (roll < 76)
                    issue_request(MODE_POP, pick_byte(), pick_amount());
                else if (roll < 84)
                    issue_request(3'($urandom_range(MODE_CODE_MAX, MODE_END + 1)),
                                  pick_byte(), pick_amount());
                else if (roll < 86 && allow_end)
                    issue_request(MODE_END, pick_byte(), pick_amount());
                else
                    issue_request(MODE_WRITE, pick_byte(), pick_amount());
                sent++;
            end
        end
    endtask

    // every operation but end of input, and unused codes, on an empty and a lightly filled buffer
    task automatic test_basic_requests();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        issue_request(MODE_READ, 8'h00, '0);
        issue_request(MODE_PEEK, 8'h00, '0);
        issue_request(MODE_POP, 8'h00, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
        issue_request(3'(MODE_END + 1), 8'hFF, CNT_W'(AMOUNT_MAX));
        issue_request(3'(MODE_END + 2), 8'h00, '0);
        issue_request(3'(MODE_CODE_MAX), 8'hFF, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_WRITE, 8'h00, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_WRITE, 8'hFF, '0);
        issue_request(MODE_WRITE, 8'hA5, '0);
        issue_request(MODE_WRITE, 8'h5A, '0);
        issue_request(MODE_PEEK, 8'hFF, CNT_W'(0));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(3));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(4));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_READ, 8'hFF, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_POP, 8'h00, CNT_W'(0));
        issue_request(MODE_POP, 8'h00, CNT_W'(1));
        issue_request(MODE_WRITE, 8'h3C, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_READ, 8'h00, '0);
    endtask

    // capacity of one, zero, above the depth and below the fill level
    task automatic test_capacity_limits();
        program_capacity(1);
        issue_request(MODE_WRITE, 8'h11, '0);
        issue_request(MODE_WRITE, 8'h22, '0);
        issue_request(MODE_READ, 8'h00, '0);
        program_capacity(0);
        issue_request(MODE_WRITE, 8'h33, '0);
        issue_request(MODE_READ, 8'h00, '0);
        program_capacity(CFG_DATA_W'(CAPACITY_RESET));
        repeat (10) issue_request(MODE_WRITE, pick_byte(), '0);
        // upper bits of the write data carry no meaning
        program_capacity(32'hA5A5_E003);
        issue_request(MODE_WRITE, 8'h44, '0);
        issue_request(MODE_READ, 8'h00, '0);
        issue_request(MODE_READ, 8'h00, '0);
        issue_request(MODE_PEEK, 8'h00, CNT_W'(0));
        issue_request(MODE_WRITE, 8'h55, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(6));
        issue_request(MODE_WRITE, 8'h66, '0);
        issue_request(MODE_WRITE, 8'h77, '0);
        program_capacity(AMOUNT_MAX);
        issue_request(MODE_WRITE, 8'h88, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
    endtask

    // fill a small capacity to the brim, drop writes, peek at the edges and drain
    task automatic test_full_buffer();
        program_capacity(CFG_DATA_W'(SMALL_CAP));
        tx_idle_pct = 19;
        rx_stall_pct = 19;
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
        while (mirror_room() != 0)
            issue_request(MODE_WRITE, pick_byte(), pick_amount());
        repeat (3) issue_request(MODE_WRITE, pick_byte(), '0);
        issue_request(MODE_PEEK, 8'h00, CNT_W'(SMALL_CAP - 1));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(SMALL_CAP));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(DEPTH - 1));
        issue_request(MODE_POP, 8'h00, CNT_W'(SMALL_CAP / 2));
        while (mirror_room() != 0)
            issue_request(MODE_WRITE, pick_byte(), '0);
        repeat (8) issue_request(MODE_PEEK, 8'h00, CNT_W'($urandom_range(SMALL_CAP - 1, 0)));
        repeat (20) issue_request(MODE_READ, 8'h00, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
    endtask

    // random traffic under each idling pattern and capacity setting
    task automatic test_random_traffic();
        program_capacity(6);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random_mix(130, 1'b0);
        program_capacity(1);
        tx_idle_pct = 60;
        rx_stall_pct = 0;
        run_random_mix(130, 1'b0);
        program_capacity(AMOUNT_MAX);
        tx_idle_pct = 0;
        rx_stall_pct = 60;
        run_random_mix(130, 1'b0);
        program_capacity(CFG_DATA_W'($urandom_range(48, 2)));
        tx_idle_pct = 19;
        rx_stall_pct = 19;
        run_random_mix(130, 1'b0);
    endtask

    // end of input with bytes still buffered, draining, and writes afterwards
    task automatic test_end_of_input();
        program_capacity(CFG_DATA_W'(CAPACITY_RESET));
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        repeat (3) issue_request(MODE_WRITE, pick_byte(), '0);
        issue_request(MODE_END, 8'h00, '0);
        issue_request(MODE_END, 8'hFF, CNT_W'(AMOUNT_MAX));
        issue_request(MODE_PEEK, 8'h00, CNT_W'(2));
        repeat (3) issue_request(MODE_READ, 8'h00, '0);
        issue_request(MODE_WRITE, 8'h99, '0);
        issue_request(MODE_POP, 8'h00, CNT_W'(AMOUNT_MAX));
        issue_request(3'(MODE_END + 1), 8'h00, '0);
        program_capacity(16);
        tx_idle_pct = 19;
        rx_stall_pct = 19;
        run_random_mix(100, 1'b1);
    endtask

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_requests();
        test_capacity_limits();
        test_full_buffer();
        test_random_traffic();
        test_end_of_input();
        drain_results();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
